FILE: sv/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants and types of the set-associative LRU cache lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

  localparam int MAX_SETS      = 1024;
  localparam int WAYS          = 8;
  localparam int ADDR_W        = 32;
  localparam int WAY_W         = 3;
  localparam int STAMP_W       = 32;
  localparam int BLK_LOG2_MIN  = 2;
  localparam int BLK_LOG2_MAX  = 6;
  localparam int TAG_W         = ADDR_W - BLK_LOG2_MIN;
  localparam int SETS_LOG2_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_AW        = (SETS_LOG2_MAX > 0) ? SETS_LOG2_MAX : 1;
  localparam int ROWS          = 1 << SET_AW;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETS_LOG2        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE      = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // one set of the tag store
  typedef struct packed {
    logic [WAYS-1:0]              valid;
    logic [WAYS-1:0][TAG_W-1:0]   tag;
    logic [WAYS-1:0][STAMP_W-1:0] stamp;
  } row_t;

  typedef struct packed {
    logic             miss;
    logic [WAY_W-1:0] way;
  } sel_t;

endpackage

`default_nettype wire

FILE: sv/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/sacl_way_sel.sv
// ----------------------------------------------------------------------------
// sacl_way_sel
// Hit search, invalid-way pick and LRU victim pick over one set.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_way_sel (
  input  wire sacl_pkg::row_t                    row,
  input  wire logic [sacl_pkg::TAG_W-1:0]        tag,
  input  wire logic [sacl_pkg::WAYS-1:0]         in_use,
  output sacl_pkg::sel_t                         sel
);

  logic [sacl_pkg::WAYS-1:0]  hit_vec;
  logic [sacl_pkg::WAYS-1:0]  inv_vec;
  logic [sacl_pkg::WAYS-1:0]  lru_vec;
  logic [sacl_pkg::WAY_W-1:0] hit_way;
  logic [sacl_pkg::WAY_W-1:0] inv_way;
  logic [sacl_pkg::WAY_W-1:0] lru_way;

  // pairwise stamp compares; lowest way wins ties
  always_comb begin
    for (int i = 0; i < sacl_pkg::WAYS; i++) begin
      hit_vec[i] = in_use[i] && row.valid[i] && (row.tag[i] == tag);
      inv_vec[i] = in_use[i] && !row.valid[i];
      lru_vec[i] = in_use[i];
      for (int j = 0; j < sacl_pkg::WAYS; j++) begin
        if (in_use[j] && j < i && !(row.stamp[i] < row.stamp[j])) begin
          lru_vec[i] = 1'b0;
        end
        if (in_use[j] && j > i && (row.stamp[j] < row.stamp[i])) begin
          lru_vec[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit_way = '0;
    lru_way = '0;
    inv_way = '0;
    for (int i = sacl_pkg::WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = sacl_pkg::WAY_W'(i);
      end
      if (lru_vec[i]) begin
        lru_way = sacl_pkg::WAY_W'(i);
      end
    end
    for (int i = 0; i < sacl_pkg::WAYS; i++) begin
      if (inv_vec[i]) begin
        inv_way = sacl_pkg::WAY_W'(i);
      end
    end
  end

  always_comb begin
    sel.miss = !(|hit_vec);
    if (|hit_vec) begin
      sel.way = hit_way;
    end else if (|inv_vec) begin
      sel.way = inv_way;
    end else begin
      sel.way = lru_way;
    end
  end

endmodule

`default_nettype wire

FILE: sv/set_assoc_cache_lru_lookup_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_unit
// Set-associative tag store with LRU replacement, one set per RAM row.
//
//   channel  ports                                   direction
//   request  start, busy, address[31:0]              in (busy out)
//   result   done, miss, way_used[2:0]               out
//   config   cfg_write, cfg_index[1:0], cfg_data[3:0] in
//
// For each item the set row is read from the tag RAM in the accept cycle, then
// compared, updated and written back in the next; the result is strobed on
// done in the cycle after that, when a new item can be accepted.
// After reset a clearing pass writes all 1024 rows, busy high.
// The receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_lookup_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [sacl_pkg::ADDR_W-1:0]         address,
  output logic                                     done,
  output logic                                     miss,
  output logic      [sacl_pkg::WAY_W-1:0]          way_used,
  input  wire logic                                cfg_write,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  sacl_pkg::state_t state;
  sacl_pkg::state_t state_next;

  logic [2:0] block_bytes_log2;
  logic [3:0] sets_log2;
  logic [3:0] ways_in_use;

  logic [2:0] b_eff;
  logic [3:0] s_eff;
  logic [3:0] w_eff;
  logic [4:0] tag_shift;

  logic [sacl_pkg::ADDR_W-1:0]  shifted;
  logic [sacl_pkg::SET_AW-1:0]  set_in;
  logic [sacl_pkg::TAG_W-1:0]   tag_in;
  logic [sacl_pkg::WAYS-1:0]    use_in;

  logic [sacl_pkg::SET_AW-1:0]  q_set;
  logic [sacl_pkg::TAG_W-1:0]   q_tag;
  logic [sacl_pkg::STAMP_W-1:0] q_stamp;
  logic [sacl_pkg::WAYS-1:0]    q_use;

  logic [sacl_pkg::STAMP_W-1:0] access_counter;
  logic [sacl_pkg::SET_AW-1:0]  clr_idx;

  logic accept;
  logic clearing;
  logic looking;

  sacl_pkg::row_t              rrow;
  sacl_pkg::row_t              wrow;
  sacl_pkg::row_t              mem_wdata;
  logic [sacl_pkg::SET_AW-1:0] mem_waddr;
  logic                        mem_we;
  sacl_pkg::sel_t              sel;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes_log2 <= 3'(sacl_pkg::BLK_LOG2_MIN);
      sets_log2        <= 4'(sacl_pkg::SETS_LOG2_MAX);
      ways_in_use      <= 4'(sacl_pkg::WAYS);
    end else if (cfg_write) begin
      unique case (cfg_index)
        sacl_pkg::REG_BLOCK_BYTES_LOG2: block_bytes_log2 <= cfg_data[2:0];
        sacl_pkg::REG_SETS_LOG2:        sets_log2        <= cfg_data;
        sacl_pkg::REG_WAYS_IN_USE:      ways_in_use      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    b_eff = block_bytes_log2;
    if (block_bytes_log2 < 3'(sacl_pkg::BLK_LOG2_MIN)) begin
      b_eff = 3'(sacl_pkg::BLK_LOG2_MIN);
    end else if (block_bytes_log2 > 3'(sacl_pkg::BLK_LOG2_MAX)) begin
      b_eff = 3'(sacl_pkg::BLK_LOG2_MAX);
    end
    s_eff = sets_log2;
    if (sets_log2 > 4'(sacl_pkg::SETS_LOG2_MAX)) begin
      s_eff = 4'(sacl_pkg::SETS_LOG2_MAX);
    end
    w_eff = ways_in_use;
    if (ways_in_use == 4'd0) begin
      w_eff = 4'd1;
    end else if (ways_in_use > 4'(sacl_pkg::WAYS)) begin
      w_eff = 4'(sacl_pkg::WAYS);
    end
  end

  // address split
  always_comb begin
    tag_shift = 5'(b_eff) + 5'(s_eff);
    shifted   = address >> b_eff;
    set_in    = sacl_pkg::SET_AW'(shifted & ~({sacl_pkg::ADDR_W{1'b1}} << s_eff));
    tag_in    = sacl_pkg::TAG_W'(address >> tag_shift);
    for (int i = 0; i < sacl_pkg::WAYS; i++) begin
      use_in[i] = (i < int'(w_eff));
    end
  end

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      sacl_pkg::ST_CLEAR: begin
        if (clr_idx == '1) begin
          state_next = sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sacl_pkg::ST_LOOKUP;
        end
      end
      sacl_pkg::ST_LOOKUP: state_next = sacl_pkg::ST_IDLE;
      default:             state_next = sacl_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    clearing = 1'b0;
    looking  = 1'b0;
    unique case (state)
      sacl_pkg::ST_CLEAR:  clearing = 1'b1;
      sacl_pkg::ST_IDLE:   busy     = 1'b0;
      sacl_pkg::ST_LOOKUP: looking  = 1'b1;
      default: ;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= sacl_pkg::ST_CLEAR;
      clr_idx        <= '0;
      access_counter <= '0;
      done           <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (accept && access_counter != '1) begin
        access_counter <= access_counter + 1'b1;
      end
      done <= looking;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_set   <= set_in;
      q_tag   <= tag_in;
      q_stamp <= access_counter;
      q_use   <= use_in;
    end
    if (looking) begin
      miss     <= sel.miss;
      way_used <= sel.way;
    end
  end

  // tag store
  sacl_way_sel u_way_sel (
    .row    (rrow),
    .tag    (q_tag),
    .in_use (q_use),
    .sel    (sel)
  );

  always_comb begin
    wrow                 = rrow;
    wrow.valid[sel.way]  = 1'b1;
    wrow.tag[sel.way]    = q_tag;
    wrow.stamp[sel.way]  = q_stamp;
  end

  assign mem_we    = clearing || looking;
  assign mem_waddr = clearing ? clr_idx : q_set;
  assign mem_wdata = clearing ? '0 : wrow;

  sacl_ram #(
    .WIDTH ($bits(sacl_pkg::row_t)),
    .DEPTH (sacl_pkg::ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (set_in),
    .rdata (rrow)
  );

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == sacl_pkg::ST_LOOKUP)
    else $error("accepted item did not enter lookup");

  a_done_after_lookup: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == sacl_pkg::ST_LOOKUP))
    else $error("result strobe without lookup");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(accept) && $past(access_counter) != '1)
      |-> access_counter == $past(access_counter) + 1'b1)
    else $error("access counter did not advance");

  a_counter_sat: assert property (@(posedge clk) disable iff (rst)
    (access_counter == '1) |=> access_counter == '1)
    else $error("access counter left saturation");

endmodule

`default_nettype wire
